/* rtl/mshr_pkg.sv */
// shared types, constants and conversion function for the history ring
`timescale 1ns / 1ps

package mshr_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int HEATERS_DEF  = 4;
    localparam int CHANNELS_DEF = 5;

    localparam int TEMP_W   = 20;
    localparam int SAMPLE_W = 16;
    localparam int MASK_W   = 5;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 7;
    localparam int GEN_W    = 32;
    localparam int POS_W    = 6;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_READ = 2'd1,
        OP_DUMP = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_BAD,
        CMD_READ,
        CMD_DUMP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CH_W-1:0]    chan;
        logic [CNT_W-1:0]   max_count;
        logic [MASK_W-1:0]  flags;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

    // q16.4 to whole degrees, half away from zero, positive side saturates
    function automatic logic signed [SAMPLE_W-1:0] to_degrees(logic signed [TEMP_W-1:0] q);
        logic [TEMP_W-1:0]   mag;
        logic [TEMP_W:0]     sum;
        logic [TEMP_W-4:0]   r;
        logic [TEMP_W-4:0]   neg;
        logic signed [SAMPLE_W-1:0] res;
        mag = q[TEMP_W-1] ? (~q + 1'b1) : q;
        sum = {1'b0, mag} + (TEMP_W+1)'(8);
        r   = sum[TEMP_W:4];
        neg = ~r + 1'b1;
        if (q[TEMP_W-1])
            res = neg[SAMPLE_W-1:0];
        else if (r > (TEMP_W-3)'(32767))
            res = 16'sh7FFF;
        else
            res = r[SAMPLE_W-1:0];
        return res;
    endfunction

endpackage

/* rtl/mshr_front.sv */
// front end: accepts items, classifies them, converts push rows, queues commands
`timescale 1ns / 1ps

module mshr_front
    import mshr_pkg::*;
#(
    parameter int HEATERS  = HEATERS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic signed [TEMP_W-1:0]           temp_0,
    input  logic signed [TEMP_W-1:0]           temp_1,
    input  logic signed [TEMP_W-1:0]           temp_2,
    input  logic signed [TEMP_W-1:0]           temp_3,
    input  logic signed [TEMP_W-1:0]           bed_temp,
    input  logic [MASK_W-1:0]                  present_mask,
    input  logic [MASK_W-1:0]                  invalid_mask,
    input  logic [CH_W-1:0]                    channel,
    input  logic [CNT_W-1:0]                   max_count,
    output logic                               q_valid,
    input  logic                               q_pop,
    output cmd_t                               q_cmd,
    output logic [CHANNELS*SAMPLE_W-1:0]       q_row
);

    logic signed [TEMP_W-1:0]          heater_temp [4];
    logic [CHANNELS*SAMPLE_W-1:0]      row;
    logic [MASK_W-1:0]                 flags;
    cmd_t                              cmd;

    cmd_t                              q_cmd_reg [2];
    logic [CHANNELS*SAMPLE_W-1:0]      q_row_reg [2];
    logic                              wr_ptr_reg, wr_ptr_next;
    logic                              rd_ptr_reg, rd_ptr_next;
    logic [1:0]                        cnt_reg, cnt_next;
    logic                              push;

    assign heater_temp[0] = temp_0;
    assign heater_temp[1] = temp_1;
    assign heater_temp[2] = temp_2;
    assign heater_temp[3] = temp_3;

    // per-channel conversion, channels past the bed hold zero
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic signed [TEMP_W-1:0] q;
        if (c < HEATERS)
        begin : g_heater
            assign q        = invalid_mask[c] ? '0 : heater_temp[c];
            assign flags[c] = present_mask[c];
        end
        else if (c == HEATERS)
        begin : g_bed
            assign q        = invalid_mask[c] ? '0 : bed_temp;
            assign flags[c] = present_mask[c];
        end
        else
        begin : g_spare
            assign q        = '0;
            assign flags[c] = 1'b0;
        end
        assign row[c*SAMPLE_W +: SAMPLE_W] = to_degrees(q);
    end
    for (genvar c = CHANNELS; c < MASK_W; c++)
    begin : g_pad
        assign flags[c] = 1'b0;
    end

    always_comb
    begin
        cmd.chan      = channel;
        cmd.max_count = max_count;
        cmd.flags     = flags;
        if (op == OP_PUSH)
            cmd.kind = CMD_PUSH;
        else if (op == OP_READ && channel < CH_W'(CHANNELS))
            cmd.kind = CMD_READ;
        else if (op == OP_DUMP && channel < CH_W'(CHANNELS))
            cmd.kind = CMD_DUMP;
        else
            cmd.kind = CMD_BAD;
    end

    // two-entry command queue
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_cmd_reg[rd_ptr_reg];
    assign q_row    = q_row_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop & q_valid);
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop & q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[wr_ptr_reg] <= cmd;
            q_row_reg[wr_ptr_reg] <= row;
        end
    end

endmodule

/* rtl/mshr_back.sv */
// back end: row memory, ring pointers, command execution and result register
`timescale 1ns / 1ps

module mshr_back
    import mshr_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  cmd_t                               q_cmd,
    input  logic [CHANNELS*SAMPLE_W-1:0]       q_row,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_W-1:0]         sample,
    output logic                               sample_valid,
    output logic                               channel_present,
    output logic [GEN_W-1:0]                   generation,
    output logic [CNT_W-1:0]                   fill_level,
    output logic [POS_W-1:0]                   position,
    output logic                               last
);

    localparam int AW = $clog2(DEPTH);

    logic [CHANNELS*SAMPLE_W-1:0] mem [DEPTH];
    logic [CHANNELS*SAMPLE_W-1:0] rd_row_reg;
    logic                         rd_en, wr_en;
    logic [AW-1:0]                rd_addr;

    back_state_t                  state_reg, state_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [GEN_W-1:0]             gen_reg, gen_next;
    logic [MASK_W-1:0]            flags_reg, flags_next;
    logic [CH_W-1:0]              ch_reg, ch_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             k_reg, k_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic                         pres_reg, pres_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic                         svalid_reg, svalid_next;
    logic                         cpres_reg, cpres_next;
    logic [GEN_W-1:0]             ogen_reg, ogen_next;
    logic [CNT_W-1:0]             ofill_reg, ofill_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         last_reg, last_next;

    logic                         out_free;
    logic                         cmd_pres;
    logic [AW-1:0]                latest_idx, start_idx, step_idx;
    logic [CNT_W-1:0]             dump_n;
    logic [CNT_W-1:0]             k_inc;
    logic signed [SAMPLE_W-1:0]   sel_sample;

    assign out_free   = ~out_valid_reg | out_ready;
    assign cmd_pres   = flags_reg[q_cmd.chan];
    assign latest_idx = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign start_idx  = (count_reg == CNT_W'(DEPTH)) ? head_reg : '0;
    assign step_idx   = (idx_reg == AW'(DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign dump_n     = (q_cmd.max_count < count_reg) ? q_cmd.max_count : count_reg;
    assign k_inc      = k_reg + 1'b1;

    always_comb
    begin
        sel_sample = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (ch_reg == CH_W'(c))
                sel_sample = rd_row_reg[c*SAMPLE_W +: SAMPLE_W];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        gen_next       = gen_reg;
        flags_next     = flags_reg;
        ch_next        = ch_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        pres_next      = pres_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        sample_next    = sample_reg;
        svalid_next    = svalid_reg;
        cpres_next     = cpres_reg;
        ogen_next      = ogen_reg;
        ofill_next     = ofill_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free) begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    sample_next    = '0;
                    svalid_next    = 1'b0;
                    cpres_next     = 1'b0;
                    ogen_next      = gen_reg;
                    ofill_next     = count_reg;
                    pos_next       = '0;
                    last_next      = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_PUSH:
                        begin
                            wr_en      = 1'b1;
                            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                            if (count_reg < CNT_W'(DEPTH))
                                count_next = count_reg + 1'b1;
                            gen_next   = gen_reg + 1'b1;
                            flags_next = q_cmd.flags;
                            ogen_next  = gen_reg + 1'b1;
                            ofill_next = count_next;
                        end
                        CMD_BAD:
                        begin
                        end
                        CMD_READ, CMD_DUMP:
                        begin
                            cpres_next = cmd_pres;
                            if (count_reg != '0 &&
                                !(q_cmd.kind == CMD_DUMP && q_cmd.max_count == '0)) begin
                                // no result yet, stream from memory
                                out_valid_next = out_valid_reg & ~out_ready;
                                sample_next    = sample_reg;
                                svalid_next    = svalid_reg;
                                cpres_next     = cpres_reg;
                                ogen_next      = ogen_reg;
                                ofill_next     = ofill_reg;
                                pos_next       = pos_reg;
                                last_next      = last_reg;
                                rd_en          = 1'b1;
                                rd_addr        = (q_cmd.kind == CMD_READ) ? latest_idx : start_idx;
                                idx_next       = rd_addr;
                                n_next         = (q_cmd.kind == CMD_READ) ? CNT_W'(1) : dump_n;
                                k_next         = '0;
                                ch_next        = q_cmd.chan;
                                pres_next      = cmd_pres;
                                state_next     = BK_STREAM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_STREAM:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    sample_next    = sel_sample;
                    svalid_next    = 1'b1;
                    cpres_next     = pres_reg;
                    ogen_next      = gen_reg;
                    ofill_next     = count_reg;
                    pos_next       = k_reg[POS_W-1:0];
                    last_next      = (k_inc == n_reg);
                    if (k_inc == n_reg) begin
                        state_next = BK_IDLE;
                    end else begin
                        k_next   = k_inc;
                        rd_en    = 1'b1;
                        rd_addr  = step_idx;
                        idx_next = step_idx;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            gen_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        pres_reg   <= pres_next;
        sample_reg <= sample_next;
        svalid_reg <= svalid_next;
        cpres_reg  <= cpres_next;
        ogen_reg   <= ogen_next;
        ofill_reg  <= ofill_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    // row memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head_reg] <= q_row;
        if (rd_en)
            rd_row_reg <= mem[rd_addr];
    end

    assign out_valid       = out_valid_reg;
    assign sample          = sample_reg;
    assign sample_valid    = svalid_reg;
    assign channel_present = cpres_reg;
    assign generation      = ogen_reg;
    assign fill_level      = ofill_reg;
    assign position        = pos_reg;
    assign last            = last_reg;

endmodule

/* rtl/multi_series_history_ring.sv */
// top level of the multi-channel temperature history ring
`timescale 1ns / 1ps

// usage:
//  input channel (in_valid/in_ready) takes one item: op selects push, read latest
//  or dump; temps and masks matter on push, channel on read/dump, max_count on dump
//  output channel (out_valid/out_ready) returns one result per push, read or
//  rejected item, up to max_count results for a dump (one if nothing is stored
//  or max_count is zero), last set on the final
//  the back end executes one command at a time; a dump streams one stored row per
//  cycle from the single registered read port while the receiver takes results
//  front queue keeps accepting while the back end works or the sink stalls,
//  until both of its entries are full
//  reset clears head, fill count, generation, presence flags, the command queue
//  and the result valid flag; the row memory is not cleared, only rows already
//  pushed are ever read
//  a stalled receiver holds the result register and freezes the dump walk

module multi_series_history_ring
    import mshr_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int HEATERS  = HEATERS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic signed [TEMP_W-1:0]   temp_0,
    input  logic signed [TEMP_W-1:0]   temp_1,
    input  logic signed [TEMP_W-1:0]   temp_2,
    input  logic signed [TEMP_W-1:0]   temp_3,
    input  logic signed [TEMP_W-1:0]   bed_temp,
    input  logic [MASK_W-1:0]          present_mask,
    input  logic [MASK_W-1:0]          invalid_mask,
    input  logic [CH_W-1:0]            channel,
    input  logic [CNT_W-1:0]           max_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       sample_valid,
    output logic                       channel_present,
    output logic [GEN_W-1:0]           generation,
    output logic [CNT_W-1:0]           fill_level,
    output logic [POS_W-1:0]           position,
    output logic                       last
);

    // command queue between front and back
    logic                         q_valid;
    logic                         q_pop;
    cmd_t                         q_cmd;
    logic [CHANNELS*SAMPLE_W-1:0] q_row;

    // classify items and round push samples
    mshr_front #(
        .HEATERS  (HEATERS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .temp_0       (temp_0),
        .temp_1       (temp_1),
        .temp_2       (temp_2),
        .temp_3       (temp_3),
        .bed_temp     (bed_temp),
        .present_mask (present_mask),
        .invalid_mask (invalid_mask),
        .channel      (channel),
        .max_count    (max_count),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .q_row        (q_row)
    );

    // ring state, row memory and result register
    mshr_back #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_cmd           (q_cmd),
        .q_row           (q_row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample          (sample),
        .sample_valid    (sample_valid),
        .channel_present (channel_present),
        .generation      (generation),
        .fill_level      (fill_level),
        .position        (position),
        .last            (last)
    );

endmodule

/* tb/mshr_history_monitor.sv */
// channel monitor, history predictor and result comparison for the history ring
`timescale 1ns / 1ps

module mshr_history_monitor
    import mshr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic signed [TEMP_W-1:0]   temp_0,
    input  logic signed [TEMP_W-1:0]   temp_1,
    input  logic signed [TEMP_W-1:0]   temp_2,
    input  logic signed [TEMP_W-1:0]   temp_3,
    input  logic signed [TEMP_W-1:0]   bed_temp,
    input  logic [MASK_W-1:0]          present_mask,
    input  logic [MASK_W-1:0]          invalid_mask,
    input  logic [CH_W-1:0]            channel,
    input  logic [CNT_W-1:0]           max_count,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       sample_valid,
    input  logic                       channel_present,
    input  logic [GEN_W-1:0]           generation,
    input  logic [CNT_W-1:0]           fill_level,
    input  logic [POS_W-1:0]           position,
    input  logic                       last,
    output int                         fail_count,
    output int                         awaited
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       channel_present;
        logic [GEN_W-1:0]           generation;
        logic [CNT_W-1:0]           fill_level;
        logic [POS_W-1:0]           position;
        logic                       last;
    } reading_t;

    reading_t awaited_results[$];

    // predicted copy of the ring
    logic signed [SAMPLE_W-1:0] ring [CHANNELS_DEF][DEPTH_DEF];
    int                         head;
    int                         rows;
    logic [GEN_W-1:0]           pushes;
    logic [MASK_W-1:0]          flags;

    initial fail_count = 0;

    function automatic void add_reading(logic signed [SAMPLE_W-1:0] s, logic v, logic p,
                                        int pos, logic fin);
        reading_t r;
        r.sample          = s;
        r.sample_valid    = v;
        r.channel_present = p;
        r.generation      = pushes;
        r.fill_level      = CNT_W'(rows);
        r.position        = POS_W'(pos);
        r.last            = fin;
        awaited_results.push_back(r);
    endfunction

    task automatic compare_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [TEMP_W-1:0] t [CHANNELS_DEF];
        logic                     pres;
        reading_t                 want;
        int                       v;
        int                       mag;
        int                       n;
        int                       start;
        if (!rst_n)
        begin
            awaited_results.delete();
            head   = 0;
            rows   = 0;
            pushes = '0;
            flags  = '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (op == OP_PUSH)
                begin
                    t[0] = temp_0;
                    t[1] = temp_1;
                    t[2] = temp_2;
                    t[3] = temp_3;
                    t[4] = bed_temp;
                    for (int c = 0; c < CHANNELS_DEF; c++)
                    begin
                        v   = invalid_mask[c] ? 0 : int'(t[c]);
                        mag = ((v < 0 ? -v : v) + 8) >>> 4;
                        if (v < 0)
                            ring[c][head] = SAMPLE_W'(-mag);
                        else
                            ring[c][head] = SAMPLE_W'(mag > 32767 ? 32767 : mag);
                    end
                    flags  = present_mask;
                    head   = (head + 1) % DEPTH_DEF;
                    rows   = (rows < DEPTH_DEF) ? rows + 1 : rows;
                    pushes = pushes + 1'b1;
                    add_reading('0, 1'b0, 1'b0, 0, 1'b1);
                end
                else if (op == OP_RSVD || channel >= CHANNELS_DEF)
                    add_reading('0, 1'b0, 1'b0, 0, 1'b1);
                else
                begin
                    pres = flags[channel];
                    if (rows == 0 || (op == OP_DUMP && max_count == 0))
                        add_reading('0, 1'b0, pres, 0, 1'b1);
                    else if (op == OP_READ)
                        add_reading(ring[channel][(head + DEPTH_DEF - 1) % DEPTH_DEF],
                                    1'b1, pres, 0, 1'b1);
                    else
                    begin
                        // oldest row first, at most max_count of them
                        n     = (rows < max_count) ? rows : int'(max_count);
                        start = (head + DEPTH_DEF - rows) % DEPTH_DEF;
                        for (int k = 0; k < n; k++)
                            add_reading(ring[channel][(start + k) % DEPTH_DEF], 1'b1, pres,
                                        k, k + 1 == n);
                    end
                end
            end

            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with none awaited: sample %0d position %0d",
                           sample, position);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("sample", want.sample, sample);
                    compare_field("sample_valid", want.sample_valid, sample_valid);
                    compare_field("channel_present", want.channel_present, channel_present);
                    compare_field("generation", want.generation, generation);
                    compare_field("fill_level", want.fill_level, fill_level);
                    compare_field("position", want.position, position);
                    compare_field("last", want.last, last);
                end
            end
        end
        awaited = awaited_results.size();
    end

endmodule

/* tb/multi_series_history_ring_tb.sv */
// testbench top for the history ring: stimulus, receiver pacing, watchdog and verdict
`timescale 1ns / 1ps

module multi_series_history_ring_tb;
    import mshr_pkg::*;

    localparam int ITEMS       = 260;
    localparam int DIRECTED    = 20;
    localparam int STALL_LIMIT = 3000;  // cycles with no item moving on either side
    localparam int HOLD_AT     = 80;    // items sent before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 20;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 op;
    logic signed [TEMP_W-1:0]   temp_0;
    logic signed [TEMP_W-1:0]   temp_1;
    logic signed [TEMP_W-1:0]   temp_2;
    logic signed [TEMP_W-1:0]   temp_3;
    logic signed [TEMP_W-1:0]   bed_temp;
    logic [MASK_W-1:0]          present_mask;
    logic [MASK_W-1:0]          invalid_mask;
    logic [CH_W-1:0]            channel;
    logic [CNT_W-1:0]           max_count;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       channel_present;
    logic [GEN_W-1:0]           generation;
    logic [CNT_W-1:0]           fill_level;
    logic [POS_W-1:0]           position;
    logic                       last;
    int                         fail_count;
    int                         awaited;

    // shared pacing state between sender and receiver
    int                         items_sent = 0;
    bit                         calm = 1'b0;   // no idling on either side while set
    int                         quiet_cycles = 0;

    multi_series_history_ring uut (.*);

    mshr_history_monitor mon (.*);

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // temperatures biased toward the rounding half points and the rails
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int                       k;
        logic signed [TEMP_W-1:0] t;
        case ($urandom_range(3))
            0: t = TEMP_W'($urandom);
            1:
            begin
                k = $urandom_range(4095);
                t = TEMP_W'((k - 2048) * 16 + ($urandom_range(1) ? 8 : -8)
                            + int'($urandom_range(2)) - 1);
            end
            2:
            begin
                case ($urandom_range(3))
                    0: t = 20'sh80000;
                    1: t = 20'sh7FFFF;
                    2: t = 20'sh7FFF8;
                    default: t = 20'sh80008;
                endcase
            end
            default: t = TEMP_W'($urandom_range(4000));
        endcase
        return t;
    endfunction

    // mostly valid channels, sometimes the unused codes above the bed
    function automatic logic [CH_W-1:0] pick_channel();
        return ($urandom_range(7) == 0) ? CH_W'($urandom_range(7)) : CH_W'($urandom_range(4));
    endfunction

    // offer the item already on the payload lines, with random gaps before it
    task automatic offer();
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic push_row(input logic signed [TEMP_W-1:0] t0, input logic signed [TEMP_W-1:0] t1,
                            input logic signed [TEMP_W-1:0] t2, input logic signed [TEMP_W-1:0] t3,
                            input logic signed [TEMP_W-1:0] tb, input logic [MASK_W-1:0] pm,
                            input logic [MASK_W-1:0] im);
        op           <= OP_PUSH;
        temp_0       <= t0;
        temp_1       <= t1;
        temp_2       <= t2;
        temp_3       <= t3;
        bed_temp     <= tb;
        present_mask <= pm;
        invalid_mask <= im;
        channel      <= CH_W'($urandom);
        max_count    <= CNT_W'($urandom_range(64));
        offer();
    endtask

    // read, dump or reserved op; push-only fields carry noise
    task automatic ask(input op_t o, input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] mc);
        op           <= o;
        channel      <= ch;
        max_count    <= mc;
        temp_0       <= TEMP_W'($urandom);
        temp_1       <= TEMP_W'($urandom);
        temp_2       <= TEMP_W'($urandom);
        temp_3       <= TEMP_W'($urandom);
        bed_temp     <= TEMP_W'($urandom);
        present_mask <= MASK_W'($urandom);
        invalid_mask <= MASK_W'($urandom);
        offer();
    endtask

    // sender: directed corner cases, then a random mix dominated by pushes
    initial
    begin
        int               pick;
        logic [CNT_W-1:0] mc;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_PUSH;
        temp_0       <= '0;
        temp_1       <= '0;
        temp_2       <= '0;
        temp_3       <= '0;
        bed_temp     <= '0;
        present_mask <= '0;
        invalid_mask <= '0;
        channel      <= '0;
        max_count    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty buffer, reserved op and a bad channel before any push
        ask(OP_READ, 3'd0, 7'd0);
        ask(OP_DUMP, 3'd2, 7'd10);
        ask(OP_RSVD, 3'd1, 7'd5);
        ask(OP_READ, 3'd6, 7'd3);

        // rails, half-degree rounding both ways, positive saturation
        push_row(20'sh80000, 20'sh7FFFF, 20'sd8, -20'sd8, 20'sd7, 5'b10101, 5'b00000);
        push_row(20'sh7FFF8, 20'sh80008, -20'sd7, 20'sd24, -20'sd24, 5'b01010, 5'b10001);
        for (int c = 0; c < CHANNELS_DEF; c++)
            ask(OP_READ, CH_W'(c), 7'd0);
        ask(OP_DUMP, 3'd1, 7'd64);
        ask(OP_DUMP, 3'd4, 7'd0);
        ask(OP_DUMP, 3'd3, 7'd1);
        ask(OP_RSVD, 3'd7, 7'd64);
        ask(OP_READ, 3'd5, 7'd1);
        ask(OP_DUMP, 3'd7, 7'd4);

        // every sample flagged non-finite, every channel present
        push_row(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 5'b11111, 5'b11111);
        ask(OP_READ, 3'd2, 7'd0);
        ask(OP_DUMP, 3'd0, 7'd2);

        for (int i = 0; i < ITEMS - DIRECTED; i++)
        begin
            calm = (i >= 120 && i < 170);
            pick = $urandom_range(99);
            if (pick < 50)
                push_row(pick_temp(), pick_temp(), pick_temp(), pick_temp(), pick_temp(),
                         MASK_W'($urandom),
                         ($urandom_range(3) == 0) ? MASK_W'($urandom) : MASK_W'(0));
            else if (pick < 68)
                ask(OP_READ, pick_channel(), CNT_W'($urandom_range(64)));
            else if (pick < 90)
            begin
                case ($urandom_range(9))
                    0: mc = 7'd64;
                    1: mc = CNT_W'($urandom_range(64));
                    2: mc = 7'd0;
                    default: mc = CNT_W'($urandom_range(1, 8));
                endcase
                ask(OP_DUMP, pick_channel(), mc);
            end
            else if (pick < 95)
                ask(OP_RSVD, pick_channel(), CNT_W'($urandom_range(64)));
            else
                ask($urandom_range(1) ? OP_READ : OP_DUMP, CH_W'($urandom_range(5, 7)),
                    CNT_W'($urandom_range(64)));
        end
        in_valid <= 1'b0;
        calm = 1'b1;

        // let every awaited result arrive, then watch a little longer for strays
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, one long hold-off that backs the block up, none while calm
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && items_sent >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 23);
        end
    end

    // watchdog: any item moving on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

/* filelist.f */
rtl/mshr_pkg.sv
rtl/mshr_front.sv
rtl/mshr_back.sv
rtl/multi_series_history_ring.sv
tb/mshr_history_monitor.sv
tb/multi_series_history_ring_tb.sv
